/* rtl/bitmap_find_next_prev_set_defines.svh */
// ----------------------------------------------------------------------------
// Bitmap search assertion macros
// Shared assertion forms for the bitmap search checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIND_NEXT_PREV_SET_DEFINES_SVH
`define BITMAP_FIND_NEXT_PREV_SET_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFNP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFNP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bfnp_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap search package
// Sizes, operation codes, microcode format and the control program.
// ----------------------------------------------------------------------------
`default_nettype none

package bfnp_pkg;

  localparam int MAP_BITS  = 4096;
  localparam int WORD_BITS = 32;
  localparam int MAP_WORDS = MAP_BITS / WORD_BITS;
  localparam int POS_W     = $clog2(MAP_BITS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int FUNC_W    = 3;
  localparam int STEP_W    = 3;

  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [BIT_W-1:0]     bit_idx_t;
  typedef logic [FUNC_W-1:0]    func_t;
  typedef logic [STEP_W-1:0]    step_t;

  localparam func_t FUNC_SET   = 3'd0;
  localparam func_t FUNC_CLEAR = 3'd1;
  localparam func_t FUNC_READ  = 3'd2;
  localparam func_t FUNC_NEXT  = 3'd3;
  localparam func_t FUNC_PREV  = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_READ,
    OP_RW,
    OP_SCAN_FWD,
    OP_SCAN_BWD,
    OP_RESULT
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_FWD,
    COND_BWD,
    COND_FWD_END,
    COND_BWD_END,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic is_fwd;
    logic is_bwd;
    logic fwd_end;
    logic bwd_end;
    logic out_free;
  } status_t;

  localparam step_t STEP_IDLE     = 3'd0;
  localparam step_t STEP_READ     = 3'd1;
  localparam step_t STEP_TEST_FWD = 3'd2;
  localparam step_t STEP_TEST_BWD = 3'd3;
  localparam step_t STEP_UPDATE   = 3'd4;
  localparam step_t STEP_SCAN_FWD = 3'd5;
  localparam step_t STEP_SCAN_BWD = 3'd6;
  localparam step_t STEP_DONE     = 3'd7;

  // Control program: one word per step, two-way branch on a condition.
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    case (s)
      STEP_IDLE:     c = '{OP_CAPTURE,  COND_IN_VALID, STEP_READ,     STEP_IDLE};
      STEP_READ:     c = '{OP_READ,     COND_ALWAYS,   STEP_TEST_FWD, STEP_TEST_FWD};
      STEP_TEST_FWD: c = '{OP_NOP,      COND_FWD,      STEP_SCAN_FWD, STEP_TEST_BWD};
      STEP_TEST_BWD: c = '{OP_NOP,      COND_BWD,      STEP_SCAN_BWD, STEP_UPDATE};
      STEP_UPDATE:   c = '{OP_RW,       COND_ALWAYS,   STEP_DONE,     STEP_DONE};
      STEP_SCAN_FWD: c = '{OP_SCAN_FWD, COND_FWD_END,  STEP_DONE,     STEP_SCAN_FWD};
      STEP_SCAN_BWD: c = '{OP_SCAN_BWD, COND_BWD_END,  STEP_DONE,     STEP_SCAN_BWD};
      STEP_DONE:     c = '{OP_RESULT,   COND_OUT_FREE, STEP_IDLE,     STEP_DONE};
      default:       c = '{OP_NOP,      COND_ALWAYS,   STEP_IDLE,     STEP_IDLE};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/bfnp_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfnp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/bfnp_seq.sv */
// ----------------------------------------------------------------------------
// Bitmap search sequencer
// Step counter over the control program with conditional branches.
// ----------------------------------------------------------------------------
`default_nettype none

module bfnp_seq (
  input  logic              clk,
  input  logic              rst,
  input  bfnp_pkg::status_t status,
  output bfnp_pkg::ctrl_t   ctrl
);

  import bfnp_pkg::*;

  step_t upc;
  step_t upc_next;
  logic  take;

  assign ctrl = ucode(upc);

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:   take = 1'b1;
      COND_IN_VALID: take = status.in_valid;
      COND_FWD:      take = status.is_fwd;
      COND_BWD:      take = status.is_bwd;
      COND_FWD_END:  take = status.fwd_end;
      COND_BWD_END:  take = status.bwd_end;
      COND_OUT_FREE: take = status.out_free;
      default:       take = 1'b1;
    endcase
  end

  always_comb begin
    upc_next = take ? ctrl.tgt_true : ctrl.tgt_false;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/bfnp_dpath.sv */
// ----------------------------------------------------------------------------
// Bitmap search datapath
// Map memory, word address, bit masks, priority encoders and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfnp_dpath (
  input  logic              clk,
  input  logic              rst,
  input  bfnp_pkg::ctrl_t   ctrl,
  input  logic              in_valid,
  input  bfnp_pkg::func_t   func,
  input  bfnp_pkg::pos_t    position,
  input  logic              out_stall,
  output bfnp_pkg::status_t status,
  output logic              out_valid,
  output logic              bit_value,
  output logic              found,
  output bfnp_pkg::pos_t    found_position
);

  import bfnp_pkg::*;

  func_t    func_r;
  addr_t    waddr;
  bit_idx_t bitsel;
  logic     first;
  logic     res_bit;
  logic     res_found;
  pos_t     res_pos;
  logic     vld [MAP_WORDS];
  logic     vld_q;

  pos_t     start_pos;
  word_t    ram_rdata;
  word_t    cur_word;
  word_t    above;
  word_t    fwd_word;
  word_t    bwd_word;
  word_t    bit_mask;
  word_t    wdata;
  bit_idx_t fwd_idx;
  bit_idx_t bwd_idx;
  logic     fwd_hit;
  logic     bwd_hit;
  logic     ram_re;
  logic     ram_we;
  addr_t    raddr;
  logic     out_free;
  logic     load;

  // A word never written since reset reads as all zero.
  assign cur_word = vld_q ? ram_rdata : '0;

  // Backward search excludes its start; position zero wraps to the top bit.
  always_comb begin
    if (func == FUNC_PREV) begin
      start_pos = (position == '0) ? '1 : position - pos_t'(1);
    end else begin
      start_pos = position;
    end
  end

  assign above    = ({WORD_BITS{1'b1}} << bitsel) << 1;
  assign fwd_word = cur_word & (first ? above : '1);
  assign bwd_word = cur_word & (first ? ~above : '1)
                  & ((waddr == '0) ? ~word_t'(1) : '1);
  assign fwd_hit  = |fwd_word;
  assign bwd_hit  = |bwd_word;

  always_comb begin
    fwd_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (fwd_word[i]) begin
        fwd_idx = bit_idx_t'(i);
      end
    end
  end

  always_comb begin
    bwd_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (bwd_word[i]) begin
        bwd_idx = bit_idx_t'(i);
      end
    end
  end

  always_comb begin
    case (ctrl.op)
      OP_SCAN_FWD: raddr = waddr + addr_t'(1);
      OP_SCAN_BWD: raddr = waddr - addr_t'(1);
      default:     raddr = waddr;
    endcase
  end

  assign ram_re   = (ctrl.op == OP_READ) || (ctrl.op == OP_SCAN_FWD)
                 || (ctrl.op == OP_SCAN_BWD);
  assign ram_we   = (ctrl.op == OP_RW)
                 && ((func_r == FUNC_SET) || (func_r == FUNC_CLEAR));
  assign bit_mask = word_t'(1) << bitsel;
  assign wdata    = (func_r == FUNC_SET) ? (cur_word | bit_mask) : (cur_word & ~bit_mask);

  bfnp_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAP_WORDS; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (ram_we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      vld_q <= vld[raddr];
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_CAPTURE: begin
        func_r    <= func;
        waddr     <= start_pos[POS_W-1:BIT_W];
        bitsel    <= start_pos[BIT_W-1:0];
        first     <= 1'b1;
        res_bit   <= 1'b0;
        res_found <= 1'b0;
        res_pos   <= '0;
      end
      OP_RW: begin
        if (func_r == FUNC_READ) begin
          res_bit <= cur_word[bitsel];
        end
      end
      OP_SCAN_FWD: begin
        waddr <= waddr + addr_t'(1);
        first <= 1'b0;
        if (fwd_hit) begin
          res_found <= 1'b1;
          res_pos   <= {waddr, fwd_idx};
        end
      end
      OP_SCAN_BWD: begin
        waddr <= waddr - addr_t'(1);
        first <= 1'b0;
        if (bwd_hit) begin
          res_found <= 1'b1;
          res_pos   <= {waddr, bwd_idx};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_free = !out_valid || !out_stall;
  assign load     = (ctrl.op == OP_RESULT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bit_value      <= res_bit;
      found          <= res_found;
      found_position <= res_pos;
    end
  end

  assign status.in_valid = in_valid;
  assign status.is_fwd   = (func_r == FUNC_NEXT);
  assign status.is_bwd   = (func_r == FUNC_PREV);
  assign status.fwd_end  = fwd_hit || (waddr == addr_t'(MAP_WORDS - 1));
  assign status.bwd_end  = bwd_hit || (waddr == '0);
  assign status.out_free = out_free;

endmodule

`default_nettype wire

/* rtl/bitmap_find_next_prev_set.sv */
// ----------------------------------------------------------------------------
// Page-in-use bitmap with nearest set bit search
// Set, clear and read single marks, and find the nearest set mark above or
// below a position, in a 4096-bit map held as 128 words of 32 bits.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries an operation code (func) and a bit
// position; every input transaction yields exactly one output transaction.
// The block works on one transaction at a time. in_stall is low only while
// the sequencer waits in its idle step. Set, clear and read pass from the
// idle step through the read step, both test steps and the update step to
// the final step. A forward search passes through the read and forward test
// steps, a backward search also through the backward test step, into a scan
// loop that reads one memory word per cycle through the single read port of
// the map RAM until a hit or the end of the map. The next transaction is
// accepted in the cycle after the result is loaded into the output register.
// The result sits in an output register, so a new request is accepted and
// processed while an earlier result still waits; when the receiver stalls,
// the sequencer holds in its final step until that register frees up.
// Reset clears the sequencer and the output valid flag, and marks every map
// word as never written so that the whole map reads as zero at once, with
// no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_find_next_prev_set (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  bfnp_pkg::func_t func,
  input  bfnp_pkg::pos_t  position,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            bit_value,
  output logic            found,
  output bfnp_pkg::pos_t  found_position
);

  import bfnp_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // The sequencer steps through a small control program: capture, read the
  // first word, dispatch on the operation, then either update or read one
  // word, or scan word by word until a hit or the end of the map, and finally
  // hand the result to the output register.
  bfnp_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  bfnp_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .in_valid       (in_valid),
    .func           (func),
    .position       (position),
    .out_stall      (out_stall),
    .status         (status),
    .out_valid      (out_valid),
    .bit_value      (bit_value),
    .found          (found),
    .found_position (found_position)
  );

  // A request is taken only in the idle step, which captures it.
  assign in_stall = (ctrl.op != OP_CAPTURE);

endmodule

`default_nettype wire

/* rtl/bfnp_checker.sv */
// ----------------------------------------------------------------------------
// Bitmap search checker
// Port-level assertions for the bitmap search block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_find_next_prev_set_defines.svh"

module bfnp_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input logic           bit_value,
  input logic           found,
  input bfnp_pkg::pos_t found_position
);

  // A stalled result stays offered.
  `BFNP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // The block is busy right after taking a request.
  `BFNP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted back to back")

  // A reported set bit is never bit zero, and a position is only given with a hit.
  `BFNP_ASSERT_SAME(a_found_pos, out_valid, found == (found_position != '0), "found and position disagree")

  // A read result and a search hit never come together.
  `BFNP_ASSERT_SAME(a_read_vs_search, out_valid && bit_value, !found, "read result with search hit")

endmodule

bind bitmap_find_next_prev_set bfnp_checker u_checker (.*);

`default_nettype wire
